// File: rtl/mrsf_pkg.sv
// shared constants, codes and types of the modbus rtu slave framer
package mrsf_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    localparam int DATA_W     = 8;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int GAP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // input commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RX      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EMPTY   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_REQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TX     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_BIG_ENDIAN = 2'd2;

    // function codes
    localparam logic [DATA_W-1:0] FC_READ_COILS     = 8'd1;
    localparam logic [DATA_W-1:0] FC_READ_HOLDING   = 8'd3;
    localparam logic [DATA_W-1:0] FC_WRITE_SINGLE   = 8'd6;
    localparam logic [DATA_W-1:0] FC_WRITE_MULTIPLE = 8'd16;
    localparam logic [DATA_W-1:0] FC_LEN_LO         = 8'd1;
    localparam logic [DATA_W-1:0] FC_LEN_HI         = 8'd4;
    localparam logic [DATA_W-1:0] EXC_FLAG          = 8'h80;
    localparam logic [DATA_W-1:0] EXC_CODE          = 8'h01;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data_res;
        logic              addressed;
        logic              last_res;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic              with_payload;
        logic [DATA_W-1:0] fc;
        logic [CNT_W-1:0]  count;
    } tx_start_t;

    typedef struct packed {
        logic              busy;
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              last;
    } tx_status_t;

endpackage

// File: rtl/mrsf_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module mrsf_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/mrsf_tx.sv
// reply frame sequencer: walks header, payload memory and crc one byte at a time
module mrsf_tx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrsf_pkg::tx_start_t           start,
    input  logic [mrsf_pkg::DATA_W-1:0]   slave_address,
    input  logic                          crc_big_endian,
    input  logic                          take,
    output mrsf_pkg::tx_status_t          status,
    output logic                          rd_en,
    output logic [mrsf_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [mrsf_pkg::DATA_W-1:0]   rd_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADDR  = 4'd1;
    localparam logic [3:0] S_FUNC  = 4'd2;
    localparam logic [3:0] S_LEN   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_DATA  = 4'd5;
    localparam logic [3:0] S_EXC   = 4'd6;
    localparam logic [3:0] S_CRC_A = 4'd7;
    localparam logic [3:0] S_CRC_B = 4'd8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [15:0] crc_step(input logic [15:0] c,
                                             input logic [mrsf_pkg::DATA_W-1:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    logic [3:0]                      state_reg, state_next;
    logic [mrsf_pkg::DATA_W-1:0]     byte_reg, byte_next;
    logic                            byte_valid_reg, byte_valid_next;
    logic                            byte_last_reg, byte_last_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [mrsf_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic                            with_payload_reg, with_payload_next;
    logic [mrsf_pkg::DATA_W-1:0]     fc_reg, fc_next;
    logic [mrsf_pkg::CNT_W-1:0]      count_reg, count_next;

    logic                            load_ok;
    logic                            load_en;
    logic                            load_crc;
    logic                            load_last;
    logic [mrsf_pkg::DATA_W-1:0]     load_byte;
    logic                            has_len;
    logic [mrsf_pkg::CNT_W-1:0]      idx_inc;

    assign load_ok = !byte_valid_reg || take;
    assign has_len = (fc_reg >= mrsf_pkg::FC_LEN_LO) && (fc_reg <= mrsf_pkg::FC_LEN_HI);
    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        crc_next          = crc_reg;
        idx_next          = idx_reg;
        with_payload_next = with_payload_reg;
        fc_next           = fc_reg;
        count_next        = count_reg;
        byte_next         = byte_reg;
        byte_valid_next   = byte_valid_reg && !take;
        byte_last_next    = byte_last_reg;
        load_en           = 1'b0;
        load_crc          = 1'b1;
        load_last         = 1'b0;
        load_byte         = '0;
        rd_en             = 1'b0;
        rd_addr           = idx_reg[mrsf_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start.start)
                begin
                    with_payload_next = start.with_payload;
                    fc_next           = start.fc;
                    count_next        = start.count;
                    crc_next          = CRC_INIT;
                    idx_next          = '0;
                    state_next        = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (load_ok)
                begin
                    load_en    = 1'b1;
                    load_byte  = slave_address;
                    state_next = S_FUNC;
                end
            end
            S_FUNC:
            begin
                if (load_ok)
                begin
                    load_en = 1'b1;
                    if (with_payload_reg)
                    begin
                        load_byte = fc_reg;
                        if (has_len)
                        begin
                            state_next = S_LEN;
                        end
                        else if (count_reg != '0)
                        begin
                            state_next = S_RD;
                        end
                        else
                        begin
                            state_next = S_CRC_A;
                        end
                    end
                    else
                    begin
                        load_byte  = mrsf_pkg::EXC_FLAG | fc_reg;
                        state_next = S_EXC;
                    end
                end
            end
            S_LEN:
            begin
                if (load_ok)
                begin
                    load_en    = 1'b1;
                    load_byte  = mrsf_pkg::DATA_W'(count_reg);
                    state_next = (count_reg != '0) ? S_RD : S_CRC_A;
                end
            end
            S_RD:
            begin
                // read data shows up next cycle and holds until the next read
                rd_en      = 1'b1;
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (load_ok)
                begin
                    load_en    = 1'b1;
                    load_byte  = rd_data;
                    idx_next   = idx_inc;
                    state_next = (idx_inc == count_reg) ? S_CRC_A : S_RD;
                end
            end
            S_EXC:
            begin
                if (load_ok)
                begin
                    load_en    = 1'b1;
                    load_byte  = mrsf_pkg::EXC_CODE;
                    state_next = S_CRC_A;
                end
            end
            S_CRC_A:
            begin
                if (load_ok)
                begin
                    load_en    = 1'b1;
                    load_crc   = 1'b0;
                    load_byte  = crc_big_endian ? crc_reg[15:8] : crc_reg[7:0];
                    state_next = S_CRC_B;
                end
            end
            S_CRC_B:
            begin
                if (load_ok)
                begin
                    load_en    = 1'b1;
                    load_crc   = 1'b0;
                    load_last  = 1'b1;
                    load_byte  = crc_big_endian ? crc_reg[7:0] : crc_reg[15:8];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_en)
        begin
            byte_next       = load_byte;
            byte_valid_next = 1'b1;
            byte_last_next  = load_last;
            if (load_crc)
            begin
                crc_next = crc_step(crc_reg, load_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg         <= byte_next;
        byte_last_reg    <= byte_last_next;
        crc_reg          <= crc_next;
        idx_reg          <= idx_next;
        with_payload_reg <= with_payload_next;
        fc_reg           <= fc_next;
        count_reg        <= count_next;
    end

    assign status.busy  = (state_reg != S_IDLE) || byte_valid_reg;
    assign status.valid = byte_valid_reg;
    assign status.data  = byte_reg;
    assign status.last  = byte_last_reg;

endmodule

// File: rtl/modbus_rtu_slave_framer_unit.sv
// Modbus RTU slave framer: takes ticks, received bytes and reply payload bytes in one request
// stream and gives forwarded bytes, frame end reports and reply bytes in one result stream.
// A tick, a received byte, a stored payload byte or an ignored request is accepted whenever the
// output register is free and no reply is in progress. A reply holds off new requests until its
// final byte sits in the output register; address, function code, length, exception and CRC
// bytes load directly, each payload byte needs a payload memory read and then a load, and the
// result side may stall any of them. Payload bytes are written into a 32-entry memory that the
// reply sequencer reads back in order; the CRC takes in each non-CRC byte as it loads.
module modbus_rtu_slave_framer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mrsf_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mrsf_pkg::out_item_t               out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [1:0] RX_FULL = 2'd2;

    logic [mrsf_pkg::DATA_W-1:0]  slave_address_reg;
    logic [mrsf_pkg::GAP_W-1:0]   gap_ticks_reg;
    logic                         crc_big_endian_reg;

    logic                         receiving_reg, receiving_next;
    logic [mrsf_pkg::GAP_W-1:0]   gap_count_reg, gap_count_next;
    logic [1:0]                   rx_count_reg, rx_count_next;
    logic [mrsf_pkg::DATA_W-1:0]  first_byte_reg, first_byte_next;
    logic [mrsf_pkg::DATA_W-1:0]  function_code_reg, function_code_next;
    logic                         awaiting_reg, awaiting_next;
    logic [mrsf_pkg::CNT_W-1:0]   payload_count_reg, payload_count_next;

    logic                         out_valid_reg, out_valid_next;
    mrsf_pkg::out_item_t          out_item_reg, out_item_next;

    logic                         in_accept;
    logic                         out_free;
    logic                         hit;
    logic                         supported;
    logic                         has_room;
    logic [mrsf_pkg::CNT_W-1:0]   count_inc;
    logic                         res_valid;
    mrsf_pkg::out_item_t          res;
    mrsf_pkg::tx_start_t          tx_start;
    mrsf_pkg::tx_status_t         tx_status;
    logic                         tx_take;
    logic                         ram_we;
    logic                         ram_re;
    logic [mrsf_pkg::ADDR_W-1:0]  ram_raddr;
    logic [mrsf_pkg::DATA_W-1:0]  ram_rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !tx_status.busy && out_free;
    assign in_accept = in_valid && in_ready;
    assign tx_take   = tx_status.valid && out_free && !res_valid;

    assign hit       = (first_byte_reg == slave_address_reg);
    assign supported = (function_code_reg == mrsf_pkg::FC_READ_COILS)
                    || (function_code_reg == mrsf_pkg::FC_READ_HOLDING)
                    || (function_code_reg == mrsf_pkg::FC_WRITE_SINGLE)
                    || (function_code_reg == mrsf_pkg::FC_WRITE_MULTIPLE);
    assign has_room  = payload_count_reg < mrsf_pkg::CNT_W'(mrsf_pkg::MAX_PAYLOAD);
    assign count_inc = has_room ? payload_count_reg + 1'b1 : payload_count_reg;

    always_comb
    begin
        receiving_next     = receiving_reg;
        gap_count_next     = gap_count_reg;
        rx_count_next      = rx_count_reg;
        first_byte_next    = first_byte_reg;
        function_code_next = function_code_reg;
        awaiting_next      = awaiting_reg;
        payload_count_next = payload_count_reg;
        ram_we             = 1'b0;
        res_valid          = 1'b0;
        res                = '0;
        tx_start           = '0;
        tx_start.fc        = function_code_reg;

        if (in_accept)
        begin
            unique case (in_item.command)
                mrsf_pkg::CMD_TICK:
                begin
                    if (receiving_reg)
                    begin
                        if (gap_count_reg < gap_ticks_reg)
                        begin
                            gap_count_next = gap_count_reg + 1'b1;
                        end
                        else
                        begin
                            // silence exceeded: frame end report
                            receiving_next     = 1'b0;
                            gap_count_next     = '0;
                            rx_count_next      = '0;
                            payload_count_next = '0;
                            awaiting_next      = hit && supported;
                            res_valid          = 1'b1;
                            res.kind           = mrsf_pkg::KIND_REPORT;
                            res.data_res       = function_code_reg;
                            res.addressed      = hit;
                            if (hit && !supported)
                            begin
                                tx_start.start = 1'b1;
                            end
                        end
                    end
                end
                mrsf_pkg::CMD_RX:
                begin
                    receiving_next     = 1'b1;
                    gap_count_next     = '0;
                    awaiting_next      = 1'b0;
                    payload_count_next = '0;
                    if (rx_count_reg == 2'd0)
                    begin
                        first_byte_next    = in_item.data;
                        function_code_next = '0;
                    end
                    else if (rx_count_reg == 2'd1)
                    begin
                        function_code_next = in_item.data;
                    end
                    if (rx_count_reg != RX_FULL)
                    begin
                        rx_count_next = rx_count_reg + 1'b1;
                    end
                    res_valid    = 1'b1;
                    res.kind     = mrsf_pkg::KIND_REQ;
                    res.data_res = in_item.data;
                end
                mrsf_pkg::CMD_PAYLOAD:
                begin
                    if (awaiting_reg)
                    begin
                        ram_we             = has_room;
                        payload_count_next = count_inc;
                        if (in_item.last)
                        begin
                            tx_start.start        = 1'b1;
                            tx_start.with_payload = 1'b1;
                            tx_start.count        = count_inc;
                            awaiting_next         = 1'b0;
                            payload_count_next    = '0;
                        end
                    end
                end
                mrsf_pkg::CMD_EMPTY:
                begin
                    if (awaiting_reg)
                    begin
                        tx_start.start     = 1'b1;
                        awaiting_next      = 1'b0;
                        payload_count_next = '0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
        else if (tx_take)
        begin
            out_valid_next          = 1'b1;
            out_item_next.kind      = mrsf_pkg::KIND_TX;
            out_item_next.data_res  = tx_status.data;
            out_item_next.addressed = 1'b0;
            out_item_next.last_res  = tx_status.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg  <= 8'd1;
            gap_ticks_reg      <= 16'd4164;
            crc_big_endian_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mrsf_pkg::CFG_SLAVE_ADDRESS:  slave_address_reg  <= cfg_data[7:0];
                mrsf_pkg::CFG_GAP_TICKS:      gap_ticks_reg      <= cfg_data;
                mrsf_pkg::CFG_CRC_BIG_ENDIAN: crc_big_endian_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            gap_count_reg     <= '0;
            rx_count_reg      <= '0;
            first_byte_reg    <= '0;
            function_code_reg <= '0;
            awaiting_reg      <= 1'b0;
            payload_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            receiving_reg     <= receiving_next;
            gap_count_reg     <= gap_count_next;
            rx_count_reg      <= rx_count_next;
            first_byte_reg    <= first_byte_next;
            function_code_reg <= function_code_next;
            awaiting_reg      <= awaiting_next;
            payload_count_reg <= payload_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // the last payload write lands well before the sequencer reaches its first read
    mrsf_ram #(
        .DEPTH (mrsf_pkg::MAX_PAYLOAD),
        .WIDTH (mrsf_pkg::DATA_W)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (payload_count_reg[mrsf_pkg::ADDR_W-1:0]),
        .wr_data (in_item.data),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mrsf_tx u_tx (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (tx_start),
        .slave_address  (slave_address_reg),
        .crc_big_endian (crc_big_endian_reg),
        .take           (tx_take),
        .status         (tx_status),
        .rd_en          (ram_re),
        .rd_addr        (ram_raddr),
        .rd_data        (ram_rdata)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        payload_count_reg <= mrsf_pkg::CNT_W'(mrsf_pkg::MAX_PAYLOAD))
        else $error("payload count beyond capacity");

    a_no_pending_while_tx: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> !tx_status.busy)
        else $error("reply pending while a reply is transmitting");

    a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.last_res) |-> (out_item_reg.kind == mrsf_pkg::KIND_TX))
        else $error("frame end mark on a non-transmit result");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tx_start.start |=> tx_status.busy && !awaiting_reg)
        else $error("reply start did not engage the sequencer");
`endif

endmodule
